// File: rtl/core/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared types and constants of the timed command queue: opcodes, the stored
// entry layout and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int CMD_W  = 8;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } tcq_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] due;
    logic [DATA_W-1:0] ivl;
  } tcq_entry_t;

  localparam int ENTRY_W = $bits(tcq_entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic clear_q;
    logic rd_head;
    logic pop_head;
    logic ins_start;
    logic ins_shift;
    logic ins_place;
    logic out_load;
  } tcq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic head_due;
    logic head_periodic;
    logic new_lt;
    logic k_one;
  } tcq_status_t;

endpackage

// File: rtl/core/tcq_ram.sv
// ----------------------------------------------------------------------------
// tcq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/tcq_ctrl.sv
// ----------------------------------------------------------------------------
// tcq_ctrl
// Controller of the timed command queue: sequences insert, clear and tick
// operations and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module tcq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_opcode,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcq_pkg::tcq_cmd_t    cmd,
  input  tcq_pkg::tcq_status_t status
);
  import tcq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS_START = 6'b000010,
    S_INS_CMP   = 6'b000100,
    S_INS_PLACE = 6'b001000,
    S_TICK_CMP  = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          case (tcq_op_t'(in_opcode))
            OP_INSERT: begin
              state_nxt = status.full ? S_DONE : S_INS_START;
            end
            OP_CLEAR: begin
              cmd.clear_q = 1'b1;
              state_nxt   = S_DONE;
            end
            OP_TICK: begin
              if (status.empty) begin
                state_nxt = S_DONE;
              end else begin
                cmd.rd_head = 1'b1;
                state_nxt   = S_TICK_CMP;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS_START: begin
        cmd.ins_start = 1'b1;
        state_nxt     = status.empty ? S_INS_PLACE : S_INS_CMP;
      end
      S_INS_CMP: begin
        if (status.new_lt) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = status.k_one ? S_INS_PLACE : S_INS_CMP;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_INS_PLACE: begin
        cmd.ins_place = 1'b1;
        state_nxt     = S_DONE;
      end
      S_TICK_CMP: begin
        if (status.head_due) begin
          cmd.pop_head = 1'b1;
          // The full check sees the occupancy from before the pop.
          state_nxt = (status.head_periodic && !status.full) ? S_INS_START : S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted beat always takes the controller out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("tcq_ctrl: ready right after an accepted beat");

  // The head is only compared when the queue holds an entry.
  a_tick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_CMP) |-> !status.empty)
    else $error("tcq_ctrl: head compare on an empty queue");

endmodule

// File: rtl/core/tcq_dp.sv
// ----------------------------------------------------------------------------
// tcq_dp
// Datapath of the timed command queue: circular entry RAM with head and tail
// pointers, insertion-sort shifter, head compare and result register.
// ----------------------------------------------------------------------------
module tcq_dp #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_opcode,
  input  logic [tcq_pkg::CMD_W-1:0]   in_command_code,
  input  logic [tcq_pkg::DATA_W-1:0]  in_command_value,
  input  logic [tcq_pkg::DATA_W-1:0]  in_due_time,
  input  logic [tcq_pkg::DATA_W-1:0]  in_repeat_interval,
  input  logic [tcq_pkg::DATA_W-1:0]  in_now_time,
  input  tcq_pkg::tcq_cmd_t           cmd,
  output tcq_pkg::tcq_status_t        status,
  output logic                        out_accepted,
  output logic                        out_fired,
  output logic [tcq_pkg::CMD_W-1:0]   out_fired_command,
  output logic [tcq_pkg::DATA_W-1:0]  out_fired_value,
  output logic [tcq_pkg::LEN_W-1:0]   out_queue_length
);
  import tcq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
  endfunction

  // Queue control state.
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  // Insertion walk: k counts entries still to be compared.
  logic [CW-1:0] k_r, k_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;

  // Payload.
  tcq_entry_t        ent_r, ent_nxt;
  logic [DATA_W-1:0] now_r, now_nxt;
  logic              res_acc_r, res_acc_nxt;
  logic              res_fired_r, res_fired_nxt;
  logic [CMD_W-1:0]  res_cmd_r, res_cmd_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  logic              out_acc_r, out_fired_r;
  logic [CMD_W-1:0]  out_cmd_r;
  logic [DATA_W-1:0] out_val_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [31:0]       occ_wide;

  // RAM ports.
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  tcq_entry_t          rd_ent;

  assign rd_ent = tcq_entry_t'(ram_rdata);

  tcq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_re = cmd.rd_head | cmd.ins_start | cmd.ins_shift;
  assign ram_we = cmd.ins_shift | cmd.ins_place;
  assign ram_waddr = wr_ptr_r;
  assign ram_wdata = cmd.ins_shift ? ram_rdata : ENTRY_W'(ent_r);

  always_comb begin
    if (cmd.rd_head) begin
      ram_raddr = head_r;
    end else if (cmd.ins_start) begin
      ram_raddr = ptr_dec(tail_r);
    end else begin
      ram_raddr = ptr_dec(rd_ptr_r);
    end
  end

  assign status.full          = (occ_r == CW'(QUEUE_DEPTH));
  assign status.empty         = (occ_r == '0);
  assign status.head_due      = (now_r >= rd_ent.due);
  assign status.head_periodic = (rd_ent.ivl != '0);
  assign status.new_lt        = (ent_r.due < rd_ent.due);
  assign status.k_one         = (k_r == CW'(1));

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    k_nxt         = k_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    ent_nxt       = ent_r;
    now_nxt       = now_r;
    res_acc_nxt   = res_acc_r;
    res_fired_nxt = res_fired_r;
    res_cmd_nxt   = res_cmd_r;
    res_val_nxt   = res_val_r;

    if (cmd.load_item) begin
      ent_nxt.cmd   = in_command_code;
      ent_nxt.val   = in_command_value;
      ent_nxt.due   = in_due_time;
      ent_nxt.ivl   = in_repeat_interval;
      now_nxt       = in_now_time;
      res_acc_nxt   = ((tcq_op_t'(in_opcode) == OP_INSERT) && !status.full) ||
                      (tcq_op_t'(in_opcode) == OP_CLEAR);
      res_fired_nxt = 1'b0;
      res_cmd_nxt   = '0;
      res_val_nxt   = '0;
    end
    if (cmd.clear_q) begin
      occ_nxt  = '0;
      tail_nxt = head_r;
    end
    if (cmd.pop_head) begin
      res_fired_nxt = 1'b1;
      res_cmd_nxt   = rd_ent.cmd;
      res_val_nxt   = rd_ent.val;
      // Candidate for a periodic re-insert; the sum wraps modulo 2^32.
      ent_nxt       = rd_ent;
      ent_nxt.due   = rd_ent.due + rd_ent.ivl;
      head_nxt      = ptr_inc(head_r);
      occ_nxt       = occ_r - CW'(1);
    end
    if (cmd.ins_start) begin
      k_nxt      = occ_r;
      wr_ptr_nxt = tail_r;
      rd_ptr_nxt = ptr_dec(tail_r);
    end
    if (cmd.ins_shift) begin
      k_nxt      = k_r - CW'(1);
      wr_ptr_nxt = rd_ptr_r;
      rd_ptr_nxt = ptr_dec(rd_ptr_r);
    end
    if (cmd.ins_place) begin
      occ_nxt  = occ_r + CW'(1);
      tail_nxt = ptr_inc(tail_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      k_r      <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      k_r      <= k_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  assign occ_wide = 32'(occ_r);

  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    now_r       <= now_nxt;
    res_acc_r   <= res_acc_nxt;
    res_fired_r <= res_fired_nxt;
    res_cmd_r   <= res_cmd_nxt;
    res_val_r   <= res_val_nxt;
    if (cmd.out_load) begin
      out_acc_r   <= res_acc_r;
      out_fired_r <= res_fired_r;
      out_cmd_r   <= res_cmd_r;
      out_val_r   <= res_val_r;
      out_len_r   <= occ_wide[LEN_W-1:0];
    end
  end

  assign out_accepted      = out_acc_r;
  assign out_fired         = out_fired_r;
  assign out_fired_command = out_cmd_r;
  assign out_fired_value   = out_val_r;
  assign out_queue_length  = out_len_r;

  // Tail must always sit occupancy slots past the head, modulo the depth.
  logic [AW:0] ptr_sum, ptr_wrap;
  assign ptr_sum  = {1'b0, head_r} + (AW+1)'(occ_r);
  assign ptr_wrap = (ptr_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    ptr_sum - (AW+1)'(QUEUE_DEPTH) : ptr_sum;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(QUEUE_DEPTH))
    else $error("tcq_dp: occupancy beyond depth");

  a_ptr_coherent: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_wrap[AW-1:0] == tail_r)
    else $error("tcq_dp: head, tail and occupancy disagree");

  a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_place |-> !status.full)
    else $error("tcq_dp: entry placed into a full queue");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_shift |-> (k_r != '0) && (k_r <= occ_r))
    else $error("tcq_dp: shift outside the occupied range");

endmodule

// File: rtl/core/timed_command_queue_core.sv
// ----------------------------------------------------------------------------
// timed_command_queue_core
// A queue of up to QUEUE_DEPTH commands kept sorted by due time. Each input
// beat carries an opcode: insert stores a command after every entry due at
// the same time or earlier (refused with accepted low when full), clear
// empties the queue, and tick compares now_time with the head and, if the
// head is due, removes it and reports its command and value; a periodic head
// goes back in with its due time advanced by its interval (modulo 2^32),
// unless the queue was full before the tick. Every input beat produces
// exactly one result beat carrying the occupancy after the operation (low
// six bits). Entries live in a single circular RAM, so an insert walks from
// the tail toward the head, moving one entry per cycle: the insert reads the
// entry before the tail, shifts each later-due entry up one slot, then places
// the new entry; a refused insert, a clear or a no-op goes straight to the
// result, a tick reads and compares the head (skipped on an empty queue),
// and a periodic fire adds the re-insert walk on top. The one-entry-per-cycle
// shift through the RAM write port sets the worst case. A new beat is
// accepted once the previous one's result has been registered, even if that
// result is still waiting on out_ready.
// ----------------------------------------------------------------------------
module timed_command_queue_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [tcq_pkg::CMD_W-1:0]   in_command_code,
  input  logic [tcq_pkg::DATA_W-1:0]  in_command_value,
  input  logic [tcq_pkg::DATA_W-1:0]  in_due_time,
  input  logic [tcq_pkg::DATA_W-1:0]  in_repeat_interval,
  input  logic [tcq_pkg::DATA_W-1:0]  in_now_time,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic                        out_fired,
  output logic [tcq_pkg::CMD_W-1:0]   out_fired_command,
  output logic [tcq_pkg::DATA_W-1:0]  out_fired_value,
  output logic [tcq_pkg::LEN_W-1:0]   out_queue_length
);
  import tcq_pkg::*;

  // The controller decides what happens each cycle; the datapath holds the
  // queue and reports the comparisons that steer the controller.
  tcq_cmd_t    cmd;
  tcq_status_t status;

  tcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath also registers the result beat, so the queue can accept
  // the next beat while the previous result is still held on the outputs.
  tcq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_command_code    (in_command_code),
    .in_command_value   (in_command_value),
    .in_due_time        (in_due_time),
    .in_repeat_interval (in_repeat_interval),
    .in_now_time        (in_now_time),
    .cmd                (cmd),
    .status             (status),
    .out_accepted       (out_accepted),
    .out_fired          (out_fired),
    .out_fired_command  (out_fired_command),
    .out_fired_value    (out_fired_value),
    .out_queue_length   (out_queue_length)
  );

endmodule
